// ----- rtl/ptw_pkg.sv -----
// shared types, constants and decode helpers for the page table walker
`timescale 1ns / 1ps
`default_nettype none
package ptw_pkg;

  // walk geometry
  localparam int LEVEL_COUNT      = 3;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int VPN_BITS         = 9;
  localparam int LVL_W            = 2;

  // field widths
  localparam int PA_W        = 56;
  localparam int VA_W        = 39;
  localparam int PTE_W       = 64;
  localparam int PPN_W       = 44;
  localparam int PPN_LSB     = 10;
  localparam int ENTRY_SHIFT = 3;

  // entry flag positions
  localparam int PTE_V = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W_BIT = 2;
  localparam int PTE_X = 3;

  typedef enum logic {
    OP_REQUEST  = 1'b0,
    OP_RESPONSE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_FETCH = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_RESERVED   = 3'd2,
    ST_NONLEAF    = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_READ_ERR   = 3'd5
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [PA_W-1:0]   root_addr;
    logic [VA_W-1:0]   virt_addr;
    logic [PTE_W-1:0]  pte_word;
    logic              read_failed;
  } in_word_t;

  typedef struct packed {
    kind_t            kind;
    logic [PA_W-1:0]  fetch_addr;
    logic [PA_W-1:0]  phys_addr;
    status_t          status;
  } out_word_t;

  // virtual page number of one level
  function automatic logic [VPN_BITS-1:0] vpn_of(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
    logic [VA_W-1:0]     sh;
    logic [VPN_BITS-1:0] v;
    v = '0;
    for (int i = 0; i < (1 << LVL_W); i++) begin
      sh = va >> (PAGE_OFFSET_BITS + i * VPN_BITS);
      if (lvl == LVL_W'(i)) v = sh[VPN_BITS-1:0];
    end
    return v;
  endfunction

  // ppn bits below the superpage boundary of a level
  function automatic logic [PPN_W-1:0] low_mask(input logic [LVL_W-1:0] lvl);
    logic [PPN_W-1:0] m;
    for (int j = 0; j < PPN_W; j++) begin
      m[j] = (j < int'(lvl) * VPN_BITS);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/page_table_walker_unit.sv -----
// page table walker: request and entry decode with a registered result word
//
// usage: the input channel carries two kinds of word. a request word
// (operation = request) starts a walk from the root table address and
// the virtual address, and the walker answers with a fetch word naming the
// top level entry. the caller reads that entry and sends it back as a
// response word; the walker answers with either the next fetch word or a
// finished word holding the physical address and a status code. a request
// that arrives mid walk drops the old walk. a response while idle gives
// no word at all.
//
// timing: each input word is decoded combinationally; its result is
// registered the cycle after it is taken, one word per cycle unless a
// held word stalls. the decode is one address add and leaf compose logic.
//
// reset clears the walk state and empties the output register. when the
// receiver stalls while a word is held, in_stall rises in the same cycle
// and no input word is taken until the held word has been taken.
`timescale 1ns / 1ps
`default_nettype none
module page_table_walker_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptw_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ptw_pkg::out_word_t      out_word
);
  import ptw_pkg::*;

  // walk state
  logic             busy, busy_next;
  logic [LVL_W-1:0] cur_level, cur_level_next;
  logic [VA_W-1:0]  held_vaddr, held_vaddr_next;
  logic [PA_W-1:0]  table_base, table_base_next;

  logic             accept;
  logic             has_result;
  out_word_t        res;

  // entry decode
  logic             pte_v, pte_r, pte_w, pte_x;
  logic [PPN_W-1:0] ppn;
  logic [PPN_W-1:0] lmask;
  logic [PPN_W-1:0] page;
  logic             do_fetch;
  logic [PA_W-1:0]  fetch_sum;

  // output register frees up when empty or being taken
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pte_v = in_word.pte_word[PTE_V];
  assign pte_r = in_word.pte_word[PTE_R];
  assign pte_w = in_word.pte_word[PTE_W_BIT];
  assign pte_x = in_word.pte_word[PTE_X];
  assign ppn   = in_word.pte_word[PPN_LSB +: PPN_W];
  assign lmask = low_mask(cur_level);

  // superpage: low ppn fields come from the virtual page numbers
  assign page = (ppn & ~lmask)
              | (PPN_W'(held_vaddr[VA_W-1:PAGE_OFFSET_BITS]) & lmask);

  always_comb begin
    busy_next       = busy;
    cur_level_next  = cur_level;
    held_vaddr_next = held_vaddr;
    table_base_next = table_base;
    has_result      = 1'b0;
    do_fetch        = 1'b0;
    res             = '{kind: KIND_DONE, fetch_addr: '0, phys_addr: '0, status: ST_OK};

    if (in_word.operation == OP_REQUEST) begin
      // new walk, page offset of the root is dropped
      held_vaddr_next = in_word.virt_addr;
      table_base_next = {in_word.root_addr[PA_W-1:PAGE_OFFSET_BITS],
                         {PAGE_OFFSET_BITS{1'b0}}};
      cur_level_next  = LVL_W'(LEVEL_COUNT - 1);
      busy_next       = 1'b1;
      has_result      = 1'b1;
      do_fetch        = 1'b1;
    end else if (busy) begin
      has_result = 1'b1;
      if (in_word.read_failed) begin
        busy_next  = 1'b0;
        res.status = ST_READ_ERR;
      end else if (!pte_v) begin
        busy_next  = 1'b0;
        res.status = ST_INVALID;
      end else if (!pte_r && pte_w) begin
        busy_next  = 1'b0;
        res.status = ST_RESERVED;
      end else if (pte_r || pte_x) begin
        // leaf; a misaligned superpage still reports the composed address
        busy_next     = 1'b0;
        res.phys_addr = {page, held_vaddr[PAGE_OFFSET_BITS-1:0]};
        res.status    = ((ppn & lmask) != '0) ? ST_MISALIGNED : ST_OK;
      end else if (cur_level == '0) begin
        busy_next  = 1'b0;
        res.status = ST_NONLEAF;
      end else begin
        // pointer to the next level table
        table_base_next = {ppn, {PAGE_OFFSET_BITS{1'b0}}};
        cur_level_next  = cur_level - LVL_W'(1);
        do_fetch        = 1'b1;
      end
    end

    // entry address of the level now being walked
    fetch_sum = table_base_next
              + PA_W'({vpn_of(held_vaddr_next, cur_level_next), {ENTRY_SHIFT{1'b0}}});
    if (do_fetch) begin
      res.kind       = KIND_FETCH;
      res.fetch_addr = fetch_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cur_level  <= '0;
      held_vaddr <= '0;
      table_base <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy       <= busy_next;
        cur_level  <= cur_level_next;
        held_vaddr <= held_vaddr_next;
        table_base <= table_base_next;
        out_valid  <= has_result;
        if (has_result) out_word <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a response while idle gives no word
  a_idle_resp_silent: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.operation == OP_RESPONSE && !busy |=> !out_valid)
    else $error("response while idle produced a word");

  // a request always answers with a fetch and starts a walk
  a_req_fetch: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.operation == OP_REQUEST
    |=> out_valid && out_word.kind == KIND_FETCH && busy)
    else $error("request did not start a walk");

  // a failed read ends the walk with a read error
  a_read_err: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.operation == OP_RESPONSE && busy && in_word.read_failed
    |=> !busy && out_word.status == ST_READ_ERR && out_word.kind == KIND_DONE)
    else $error("read error not reported");

  // fetch words point at entry aligned addresses
  a_fetch_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.kind == KIND_FETCH
    |-> out_word.fetch_addr[ENTRY_SHIFT-1:0] == '0 && out_word.phys_addr == '0)
    else $error("misaligned fetch word");

  // the level stays inside the table depth during a walk
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> int'(cur_level) < LEVEL_COUNT)
    else $error("walk level out of range");

endmodule
`default_nettype wire

// ----- test/page_table_walker_unit_tb.sv -----
// self-checking testbench for the page table walker: random walks, stray words and back-pressure
`timescale 1ns / 1ps
module page_table_walker_unit_tb;
  import ptw_pkg::*;

  localparam int RANDOM_WORDS = 750;  // walker words in the random part
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the result register
  localparam int DRAIN_CYCLES = 20;   // quiet cycles after the last reply

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  page_table_walker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  // words waiting to be offered, and replies the walker still owes
  in_word_t  walk_words_q[$];
  out_word_t replies_due[$];

  int   stim_words     = 0;   // counted words queued so far
  int   total_words    = 0;   // everything queued, strays included
  int   accepted_words = 0;
  int   error_count    = 0;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;
  int   hold_left      = 0;
  logic hold_done      = 1'b0;
  logic word_taken     = 1'b0;

  // walker state as the predictor sees it
  logic             walk_busy  = 1'b0;
  logic [LVL_W-1:0] walk_level = '0;
  logic [VA_W-1:0]  walk_va    = '0;
  logic [PA_W-1:0]  walk_base  = '0;

  function automatic logic [PA_W-1:0] rand_pa();
    return PA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    return VA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PPN_W-1:0] rand_ppn();
    return PPN_W'({$urandom, $urandom});
  endfunction

  // entry with the given flags and ppn; the spare bits (U, G, A, D, RSW, top) are random
  function automatic logic [PTE_W-1:0] pte_of(input logic v, input logic r, input logic w,
                                              input logic x, input logic [PPN_W-1:0] ppn);
    logic [PTE_W-1:0] e;
    e            = {$urandom, $urandom};
    e[PTE_V]     = v;
    e[PTE_R]     = r;
    e[PTE_W_BIT] = w;
    e[PTE_X]     = x;
    e[PPN_LSB +: PPN_W] = ppn;
    return e;
  endfunction

  // response word; the request-only fields carry junk the walker must ignore
  function automatic in_word_t response_word(input logic [PTE_W-1:0] pte, input logic failed);
    in_word_t w;
    w.operation   = OP_RESPONSE;
    w.root_addr   = rand_pa();
    w.virt_addr   = rand_va();
    w.pte_word    = pte;
    w.read_failed = failed;
    return w;
  endfunction

  task automatic queue_request(input logic [PA_W-1:0] root, input logic [VA_W-1:0] va);
    in_word_t w;
    w.operation   = OP_REQUEST;
    w.root_addr   = root;
    w.virt_addr   = va;
    w.pte_word    = {$urandom, $urandom};
    w.read_failed = ($urandom_range(0, 1) != 0);
    walk_words_q.push_back(w);
    stim_words++;
  endtask

  task automatic queue_response(input logic [PTE_W-1:0] pte, input logic failed);
    walk_words_q.push_back(response_word(pte, failed));
    stim_words++;
  endtask

  // one walk from the top level with random entries; it ends on a leaf, a fault,
  // a read error, a random entry, or it is simply abandoned for the next request
  task automatic queue_walk();
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] low;
    logic             r;
    logic             w;
    logic             x;
    int               pick;
    queue_request(rand_pa(), rand_va());
    for (int lvl = LEVEL_COUNT - 1; lvl >= 0; lvl--) begin
      ppn  = rand_ppn();
      low  = (PPN_W'(1) << (lvl * VPN_BITS)) - 1'b1;
      x    = ($urandom_range(0, 1) != 0);
      r    = ($urandom_range(0, 1) != 0) || !x;
      w    = r && ($urandom_range(0, 1) != 0);
      pick = $urandom_range(0, 99);
      // pointers dominate above the last level so most walks go deep;
      // a pointer at the last level is the non-leaf fault
      if (pick < ((lvl != 0) ? 60 : 8)) begin
        queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, ppn), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          queue_response(pte_of(1'b1, r, w, x, ppn & ~low), 1'b0);
        end else if (pick < 60) begin
          if (lvl != 0) ppn[$urandom_range(0, lvl * VPN_BITS - 1)] = 1'b1;
          queue_response(pte_of(1'b1, r, w, x, ppn), 1'b0);
        end else if (pick < 70) begin
          queue_response(pte_of(1'b0, r, !w, x, ppn), 1'b0);
        end else if (pick < 78) begin
          queue_response(pte_of(1'b1, 1'b0, 1'b1, x, ppn), 1'b0);
        end else if (pick < 86) begin
          queue_response({$urandom, $urandom}, 1'b1);
        end else if (pick < 93) begin
          queue_response({$urandom, $urandom}, $urandom_range(0, 1) != 0);
        end
        break;
      end
    end
  endtask

  // address of the entry for the current level
  function automatic logic [PA_W-1:0] next_entry_addr();
    logic [VA_W-1:0] shifted;
    shifted = walk_va >> (PAGE_OFFSET_BITS + int'(walk_level) * VPN_BITS);
    return walk_base + (PA_W'(shifted[VPN_BITS-1:0]) << ENTRY_SHIFT);
  endfunction

  // decode one accepted word and queue the reply it causes, if any
  task automatic predict_reply(input in_word_t w);
    out_word_t        want;
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] low;
    logic [PPN_W-1:0] page;
    logic [VA_W-1:0]  vpage;
    want = '0;
    if (w.operation == OP_REQUEST) begin
      // a request always restarts, even mid walk; root page offset is dropped
      walk_va         = w.virt_addr;
      walk_base       = {w.root_addr[PA_W-1:PAGE_OFFSET_BITS], {PAGE_OFFSET_BITS{1'b0}}};
      walk_level      = LVL_W'(LEVEL_COUNT - 1);
      walk_busy       = 1'b1;
      want.kind       = KIND_FETCH;
      want.fetch_addr = next_entry_addr();
      replies_due.push_back(want);
      return;
    end
    // a response with no walk in progress is dropped silently
    if (!walk_busy) return;
    walk_busy = 1'b0;
    want.kind = KIND_DONE;
    ppn       = w.pte_word[PPN_LSB +: PPN_W];
    low       = (PPN_W'(1) << (int'(walk_level) * VPN_BITS)) - 1'b1;
    if (w.read_failed) begin
      want.status = ST_READ_ERR;
    end else if (!w.pte_word[PTE_V]) begin
      want.status = ST_INVALID;
    end else if (!w.pte_word[PTE_R] && w.pte_word[PTE_W_BIT]) begin
      want.status = ST_RESERVED;
    end else if (w.pte_word[PTE_R] || w.pte_word[PTE_X]) begin
      // superpage: low ppn fields come from the vpn; a misaligned one still
      // reports the composed address
      vpage          = walk_va >> PAGE_OFFSET_BITS;
      page           = (ppn & ~low) | (PPN_W'(vpage) & low);
      want.phys_addr = PA_W'({page, walk_va[PAGE_OFFSET_BITS-1:0]});
      want.status    = ((ppn & low) != '0) ? ST_MISALIGNED : ST_OK;
    end else if (walk_level == '0) begin
      want.status = ST_NONLEAF;
    end else begin
      // pointer: descend one level and ask for the next entry
      walk_busy       = 1'b1;
      walk_base       = PA_W'({ppn, {PAGE_OFFSET_BITS{1'b0}}});
      walk_level      = walk_level - 1'b1;
      want.kind       = KIND_FETCH;
      want.fetch_addr = next_entry_addr();
    end
    replies_due.push_back(want);
  endtask

  task automatic check_reply(input out_word_t got);
    out_word_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected word: kind %0d fetch_addr %h phys_addr %h status %0d",
             got.kind, got.fetch_addr, got.phys_addr, got.status);
      error_count++;
      return;
    end
    want = replies_due.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      error_count++;
    end
    if (got.fetch_addr !== want.fetch_addr) begin
      $error("fetch_addr: expected %h, got %h", want.fetch_addr, got.fetch_addr);
      error_count++;
    end
    if (got.phys_addr !== want.phys_addr) begin
      $error("phys_addr: expected %h, got %h", want.phys_addr, got.phys_addr);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
  endtask

  // driver: a new word goes out at the falling edge once the last one was
  // taken; a stalled word is held unchanged
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (walk_words_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= walk_words_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off early in the run, counted here, while the sender keeps going
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_words >= total_words / 10) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: replies are checked before the word accepted at the same edge
  // is predicted, since a reply always belongs to an older word
  always @(posedge clk) begin
    word_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) check_reply(out_word);
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        predict_reply(in_word);
        accepted_words++;
        // idle phases follow progress through the run
        case (accepted_words * 5 / total_words)
          1: begin send_idle_pct = 85; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 85; end
          3: begin send_idle_pct = 11; stall_pct = 11; end
          default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [PPN_W-1:0] giga;
    int               pick;
    int               directed_words;
    giga = '1;
    giga[(LEVEL_COUNT-1)*VPN_BITS-1:0] = '0;

    // stray response straight out of reset
    walk_words_q.push_back(response_word(pte_of(1'b1, 1'b1, 1'b1, 1'b1, '1), 1'b0));
    // all-ones addresses with an unaligned root, aligned leaf at the top level
    queue_request('1, '1);
    queue_response(pte_of(1'b1, 1'b1, 1'b0, 1'b1, giga), 1'b0);
    // zero addresses, pointers to the top and the bottom of memory, 4k leaf
    queue_request('0, '0);
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, '1), 1'b0);
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, '0), 1'b0);
    queue_response(pte_of(1'b1, 1'b1, 1'b1, 1'b1, '1), 1'b0);
    // read error
    queue_request(rand_pa(), rand_va());
    queue_response('1, 1'b1);
    // invalid entry
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b0, 1'b1, 1'b1, 1'b1, rand_ppn()), 1'b0);
    // reserved write-only encoding
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b0, 1'b1, 1'b1, rand_ppn()), 1'b0);
    // pointer at the last level
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, rand_ppn()), 1'b0);
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, rand_ppn()), 1'b0);
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, rand_ppn()), 1'b0);
    // misaligned superpages at the top and the middle level
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b1, 1'b0, 1'b0, PPN_W'(1)), 1'b0);
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, rand_ppn()), 1'b0);
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b1, PPN_W'(1) << (VPN_BITS - 1)), 1'b0);
    // new request in the middle of a walk
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b0, 1'b0, 1'b0, rand_ppn()), 1'b0);
    queue_request(rand_pa(), rand_va());
    queue_response(pte_of(1'b1, 1'b1, 1'b1, 1'b0, giga & rand_ppn()), 1'b0);
    // stray failed response after the walk is done
    walk_words_q.push_back(response_word('0, 1'b1));
    directed_words = stim_words;

    // random part: mostly whole walks, some raw noise and stray responses
    while (stim_words < directed_words + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        queue_walk();
      end else if (pick < 93) begin
        if ($urandom_range(0, 1) != 0) begin
          queue_request(rand_pa(), rand_va());
        end else begin
          queue_response({$urandom, $urandom}, $urandom_range(0, 1) != 0);
        end
      end else begin
        // end any walk with a read error so the response after it is surely stray
        queue_request(rand_pa(), rand_va());
        queue_response({$urandom, $urandom}, 1'b1);
        walk_words_q.push_back(response_word({$urandom, $urandom},
                                             $urandom_range(0, 1) != 0));
      end
    end
    total_words = walk_words_q.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // all words taken, then all replies in, then a quiet tail for strays
    while (walk_words_q.size() != 0 || in_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ptw_pkg.sv
rtl/page_table_walker_unit.sv
test/page_table_walker_unit_tb.sv
